FILE: rtl/dxt_pkg.sv
// Shared types, constants and arithmetic helpers for the DXT1/DXT3 block decoder.
// No dependencies.
package dxt_pkg;

    localparam int BLOCK_W      = 64;
    localparam int S_TDATA_W    = 128;
    localparam int M_TDATA_W    = 40;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int PIX_CNT_W    = 4;

    localparam logic [PIX_CNT_W-1:0] LAST_PIX = 4'd15;
    localparam logic                 REG_ALPHA_MODE = 1'b0;   // register index 0
    localparam logic [7:0]           ALPHA_OPAQUE = 8'hFF;

    localparam logic [1:0] CODE_C0    = 2'd0;
    localparam logic [1:0] CODE_C1    = 2'd1;
    localparam logic [1:0] CODE_MIX_A = 2'd2;
    localparam logic [1:0] CODE_MIX_B = 2'd3;

    typedef struct packed {
        logic [1:0] col;
        logic [1:0] row;
        logic       last;
        logic [7:0] alpha;
    } pix_ctl_t;

    // v*255/31 truncated: 8v + floor(7v/31)
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [2:0] f;
        f = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
          + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
        return {v, 3'b000} + {5'b0, f};
    endfunction

    // v*255/63 truncated: 4v + floor(v/21)
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] f;
        f = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
        return {v, 2'b00} + {6'b0, f};
    endfunction

    // weight of the second endpoint, in thirds
    function automatic logic [1:0] weight_b(input logic [1:0] code);
        logic [1:0] w;
        unique case (code)
            CODE_C0:    w = 2'd0;
            CODE_C1:    w = 2'd3;
            CODE_MIX_A: w = 2'd1;
            CODE_MIX_B: w = 2'd2;
            default:    w = 2'd0;
        endcase
        return w;
    endfunction

    // floor(x/3) for x <= 765 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

endpackage

FILE: rtl/dxt1_dxt3_block_decoder.sv
// Top level of the DXT1/DXT3 block decoder: block buffer, pixel sequencer, pipeline, APB.
// Depends on dxt_pkg and dxt_blend_chan.
//
// Usage:
//   s_axis takes one request per compressed 4x4 block: tdata[63:0] color block,
//   tdata[127:64] explicit alpha block (used only when alpha_mode is 1).
//   m_axis gives the 16 pixels in row-major order, tlast on the sixteenth.
//   APB register 0 (address 0): alpha_mode, bit 0. Write it only while idle.
// Timing:
//   A block is held in one buffer and walked by a 4-bit pixel counter, one pixel per
//   cycle while the output is not stalled, into four register stages (select/expand,
//   weight, divide, sum). The next block is taken in the cycle the sixteenth pixel of
//   the current one leaves the buffer, so blocks run gap-free.
// Reset:
//   rst_n clears the buffer valid flag, the pixel counter, all stage valid bits and alpha_mode.
// Stall:
//   While m_axis_tready is low and a pixel is shown, the whole pipeline and the
//   sequencer hold; nothing is dropped or repeated.
module dxt1_dxt3_block_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dxt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dxt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dxt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [63:0] color_block, [127:64] alpha_block
    input  logic [dxt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] pixel_col, [3:2] pixel_row, [11:4] red, [19:12] green, [27:20] blue,
    // [35:28] alpha, [39:36] zero
    output logic [dxt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast
);
    import dxt_pkg::*;

    logic                 alpha_mode_reg;
    logic                 blk_valid_reg;
    logic [BLOCK_W-1:0]   color_reg, alpha_blk_reg;
    logic [PIX_CNT_W-1:0] cnt_reg;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    pix_ctl_t             ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl_next;
    logic [1:0]           code1_reg, code_next;
    logic [7:0]           r0_reg, g0_reg, b0_reg, r1_reg, g1_reg, b1_reg;
    logic [7:0]           red, green, blue;
    logic [15:0]          e0, e1;
    logic [3:0]           nib;
    logic                 en, adv, s_acc, cfg_wr;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_ALPHA_MODE) ? {{(APB_DATA_W-1){1'b0}}, alpha_mode_reg}
                                                 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_mode_reg <= 1'b0;
        else if (cfg_wr && paddr[2] == REG_ALPHA_MODE)
            alpha_mode_reg <= pwdata[0];
    end

    // block buffer and pixel sequencer
    assign en            = !v4_reg || m_axis_tready;
    assign adv           = blk_valid_reg && en;
    assign s_axis_tready = !blk_valid_reg || (adv && cnt_reg == LAST_PIX);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (s_acc)
            begin
                blk_valid_reg <= 1'b1;
                cnt_reg       <= '0;
            end
            else if (adv)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_PIX)
                    blk_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            color_reg     <= s_axis_tdata[BLOCK_W-1:0];
            alpha_blk_reg <= s_axis_tdata[S_TDATA_W-1:BLOCK_W];
        end
    end

    // stage 1: pixel select and endpoint expansion
    always_comb
    begin
        e0        = color_reg[15:0];
        e1        = color_reg[31:16];
        code_next = color_reg[32 + 2*cnt_reg +: 2];
        nib       = alpha_blk_reg[4*cnt_reg +: 4];
        ctl_next.col   = cnt_reg[1:0];
        ctl_next.row   = cnt_reg[3:2];
        ctl_next.last  = (cnt_reg == LAST_PIX);
        ctl_next.alpha = alpha_mode_reg ? {nib, 4'b0000} : ALPHA_OPAQUE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code1_reg <= code_next;
            ctl1_reg  <= ctl_next;
            r0_reg    <= expand5(e0[15:11]);
            g0_reg    <= expand6(e0[10:5]);
            b0_reg    <= expand5(e0[4:0]);
            r1_reg    <= expand5(e1[15:11]);
            g1_reg    <= expand6(e1[10:5]);
            b1_reg    <= expand5(e1[4:0]);
            ctl2_reg  <= ctl1_reg;
            ctl3_reg  <= ctl2_reg;
            ctl4_reg  <= ctl3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= blk_valid_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stages 2..4: blend per channel
    dxt_blend_chan u_red (
        .clk  (clk),
        .en   (en),
        .code (code1_reg),
        .c0   (r0_reg),
        .c1   (r1_reg),
        .y    (red)
    );

    dxt_blend_chan u_green (
        .clk  (clk),
        .en   (en),
        .code (code1_reg),
        .c0   (g0_reg),
        .c1   (g1_reg),
        .y    (green)
    );

    dxt_blend_chan u_blue (
        .clk  (clk),
        .en   (en),
        .code (code1_reg),
        .c0   (b0_reg),
        .c1   (b1_reg),
        .y    (blue)
    );

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tlast  = ctl4_reg.last;
    assign m_axis_tdata  = {4'b0000, ctl4_reg.alpha, blue, green, red,
                            ctl4_reg.row, ctl4_reg.col};

    // checks
    a_take_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> !blk_valid_reg || cnt_reg == LAST_PIX)
        else $error("block taken while buffer busy");

    a_take_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> blk_valid_reg && cnt_reg == '0)
        else $error("sequencer not restarted on new block");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> ctl4_reg.row == 2'd3 && ctl4_reg.col == 2'd3)
        else $error("tlast on wrong pixel");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid_reg && !en |=> $stable(cnt_reg) && blk_valid_reg)
        else $error("sequencer moved during stall");

endmodule

FILE: rtl/dxt_blend_chan.sv
// One color channel of the blend: weight, divide by three, sum (three stages).
// Depends on dxt_pkg.
module dxt_blend_chan (
    input  logic       clk,
    input  logic       en,
    input  logic [1:0] code,
    input  logic [7:0] c0,
    input  logic [7:0] c1,
    output logic [7:0] y
);
    import dxt_pkg::*;

    logic [9:0] na_reg, nb_reg, na_next, nb_next;
    logic [7:0] qa_reg, qb_reg;
    logic [7:0] y_reg;
    logic [1:0] wb, wa;

    always_comb
    begin
        wb = weight_b(code);
        wa = 2'd3 - wb;
        na_next = 10'(c0) * 10'(wa);
        nb_next = 10'(c1) * 10'(wb);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg <= na_next;
            nb_reg <= nb_next;
            qa_reg <= div3(na_reg);
            qb_reg <= div3(nb_reg);
            y_reg  <= qa_reg + qb_reg;
        end
    end

    assign y = y_reg;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for dxt1_dxt3_block_decoder: stream requests in, pixels out,
// each pixel checked against a local block predictor. APB sets alpha_mode between phases.
// Depends on dxt_pkg and the decoder RTL only.
module tb_top;
    import dxt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED    = 40;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [APB_ADDR_W-1:0] ADDR_ALPHA_MODE = APB_ADDR_W'(REG_ALPHA_MODE) << 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = ADDR_ALPHA_MODE + 3'd4;
    localparam logic [APB_DATA_W-1:0] MODE_OPAQUE     = 32'd0;
    localparam logic [APB_DATA_W-1:0] MODE_EXPLICIT   = 32'd1;

    typedef struct packed {
        logic [1:0] col;
        logic [1:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t expected_q[$];
        bit     alpha_mode;
        int     errors;

        function new();
            alpha_mode = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void config_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
            if (addr == ADDR_ALPHA_MODE)
                alpha_mode = data[0];
        endfunction

        // v*255/31 and v*255/63, truncated
        function logic [7:0] widen5(logic [4:0] v);
            int unsigned x;
            x = v;
            return 8'(x * 255 / 31);
        endfunction

        function logic [7:0] widen6(logic [5:0] v);
            int unsigned x;
            x = v;
            return 8'(x * 255 / 63);
        endfunction

        // each term divided by 3 on its own
        function logic [7:0] mix(logic [7:0] a, logic [7:0] b, logic [1:0] code);
            int unsigned wb;
            int unsigned ua;
            int unsigned ub;
            ua = a;
            ub = b;
            case (code)
                CODE_C0:    wb = 0;
                CODE_C1:    wb = 3;
                CODE_MIX_A: wb = 1;
                default:    wb = 2;
            endcase
            return 8'(ua * (3 - wb) / 3 + ub * wb / 3);
        endfunction

        function void note_block(logic [63:0] cw, logic [63:0] aw);
            logic [15:0] e0;
            logic [15:0] e1;
            logic [7:0]  r0, g0, b0, r1, g1, b1;
            logic [1:0]  code;
            pixel_t      p;
            e0 = cw[15:0];
            e1 = cw[31:16];
            r0 = widen5(e0[15:11]);
            g0 = widen6(e0[10:5]);
            b0 = widen5(e0[4:0]);
            r1 = widen5(e1[15:11]);
            g1 = widen6(e1[10:5]);
            b1 = widen5(e1[4:0]);
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    code    = cw[32 + 8*r + 2*c +: 2];
                    p.col   = 2'(c);
                    p.row   = 2'(r);
                    p.red   = mix(r0, r1, code);
                    p.green = mix(g0, g1, code);
                    p.blue  = mix(b0, b1, code);
                    p.alpha = alpha_mode ? {aw[4*(4*r + c) +: 4], 4'h0} : ALPHA_OPAQUE;
                    p.last  = (r == 3) && (c == 3);
                    expected_q = {expected_q, p};
                end
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_pixel(logic [M_TDATA_W-1:0] tdata, logic tlast);
            pixel_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("pixel %h with no block pending", tdata));
                return;
            end
            want = expected_q.pop_front();
            compare_field("pixel_col", tdata[1:0], want.col);
            compare_field("pixel_row", tdata[3:2], want.row);
            compare_field("red", tdata[11:4], want.red);
            compare_field("green", tdata[19:12], want.green);
            compare_field("blue", tdata[27:20], want.blue);
            compare_field("alpha", tdata[35:28], want.alpha);
            compare_field("last_pixel", tlast, want.last);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;   // [63:0] color_block, [127:64] alpha_block
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [1:0] pixel_col, [3:2] pixel_row, [11:4] red, [19:12] green, [27:20] blue,
    // [35:28] alpha, [39:36] zero
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;   // last_pixel

    pixel_scoreboard sb = new();
    int              idle_cycles;

    dxt1_dxt3_block_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // pixel monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pixel(m_axis_tdata, m_axis_tlast);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver back-pressure: stretches of differing stall behavior
    initial
    begin
        int stall_kind;
        int span;
        int tick;
        m_axis_tready = 1'b0;
        tick = 0;
        forever begin
            stall_kind = $urandom_range(0, 3);
            span       = $urandom_range(16, 96);
            repeat (span) begin
                @(negedge clk);
                tick++;
                case (stall_kind)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_axis_tready <= (tick % 4 == 0);
                    default: m_axis_tready <= (tick % 8 < 5);
                endcase
            end
        end
    end

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.config_write(addr, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_block(logic [63:0] cw, logic [63:0] aw);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {aw, cw};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_block(cw, aw);
    endtask

    task automatic hold_off(int cycles);
        if (cycles > 0) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // stop sending and let every pending pixel come out
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_color_block();
        logic [31:0] codes;
        logic [15:0] c0;
        logic [15:0] c1;
        codes = $urandom;
        c0    = 16'($urandom);
        c1    = 16'($urandom);
        case ($urandom_range(0, 7))
            0: begin c0 = 16'hFFFF; c1 = 16'h0000; end
            1: begin c0 = 16'h0000; c1 = 16'hFFFF; end
            2: c1 = c0;
            3: codes = {16{2'($urandom_range(0, 3))}};
            default: ;
        endcase
        return {codes, c1, c0};
    endfunction

    function automatic logic [63:0] pick_alpha_block();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random(int count, bit pause_midway);
        int burst_left;
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2)
                drain();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
            end
            send_block(pick_color_block(), pick_alpha_block());
            burst_left--;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_cycles   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // opaque mode from reset: endpoint extremes, every code, c0 <= c1 still four-color
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'h0);
        send_block({32'h1B1B_1B1B, 16'hFFFF, 16'h0000}, '1);
        send_block({32'hFFAA_5500, 16'hF81F, 16'hF81F}, 64'h0);
        send_block({32'h9C6B_27D8, 16'h07E0, 16'hF800}, 64'h0);
        send_block({32'h4E93_B1C6, 16'h0821, 16'h001F}, 64'h0);
        drain();

        apb_write(ADDR_ALPHA_MODE, MODE_EXPLICIT);
        send_block({32'hE4E4_E4E4, 16'h8410, 16'h7BEF}, 64'h0);
        send_block({32'hE4E4_E4E4, 16'h8410, 16'h7BEF}, '1);
        send_block({32'h3C96_69C3, 16'h1234, 16'hFEDC}, 64'hFEDC_BA98_7654_3210);
        send_block('1, 64'h0123_4567_89AB_CDEF);
        send_block(64'h0, 64'h5A5A_A5A5_5A5A_A5A5);
        send_random(66, 1'b0);
        drain();

        // only bit 0 counts; an address past the register list is ignored
        apb_write(ADDR_ALPHA_MODE, 32'hFFFF_FFFE);
        apb_write(ADDR_UNMAPPED, MODE_EXPLICIT);
        send_random(66, 1'b0);
        drain();

        apb_write(ADDR_ALPHA_MODE, 32'h0000_0003);
        send_random(66, 1'b1);
        drain();

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
